[hw/rtl/kle_pkg.sv]
// Package for the keystroke line editor: key codes, word types, cell control
// struct and controller state type. No dependencies.
`default_nettype none

package kle_pkg;

  localparam int unsigned CapacityDefault = 32;

  localparam logic [7:0] KeyLeft  = 8'h3C;
  localparam logic [7:0] KeyRight = 8'h3E;
  localparam logic [7:0] KeyDel   = 8'h2D;

  typedef struct packed {
    logic       command;
    logic [7:0] key;
  } key_word_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       is_newline;
    logic       overflowed;
  } result_word_t;

  typedef struct packed {
    logic push_l;
    logic pop_l;
    logic push_r;
    logic pop_r;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    StIdle,
    StMove,
    StEmit,
    StNewline
  } kle_state_e;

endpackage

`default_nettype wire

[hw/rtl/keystroke_line_editor.sv]
// Keystroke line editor: gap buffer as a chain of stack cells plus controller.
// A keystroke word is taken whenever busy is low and finishes in that cycle.
// At end of line busy is high through the move, emit and newline states;
// chars come one per cycle, newline word in the first cycle busy is low.
// Speed is set by the cell chain shifting one char per cycle.
// Reset (async, active low) empties the line and clears the overflow flag.
`default_nettype none

module keystroke_line_editor
  import kle_pkg::*;
#(
  parameter int unsigned Capacity = CapacityDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  input  key_word_t    key_item_i,
  output logic         busy,
  output logic         result_valid_o,
  output result_word_t result_o
);

  localparam int unsigned CntW = $clog2(Capacity + 1);

  kle_state_e   state_q, state_d;
  logic [CntW-1:0] lcnt_q, lcnt_d, rcnt_q, rcnt_d;
  logic         ov_q, ov_d;
  logic         valid_q, valid_d;
  result_word_t res_q, res_d;
  cell_ctrl_t   ctrl;
  logic [7:0]   left_in, right_in;
  logic [7:0]   left_val [Capacity];
  logic [7:0]   right_val [Capacity];
  logic         accept;
  logic [CntW:0] total;

  assign accept = start && (state_q == StIdle);
  assign total  = {1'b0, lcnt_q} + {1'b0, rcnt_q};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept && key_item_i.command) state_d = StMove;
      end
      StMove: begin
        if (lcnt_q == '0) state_d = StEmit;
      end
      StEmit: begin
        if (rcnt_q == '0) state_d = StNewline;
      end
      StNewline: state_d = StIdle;
      default:   state_d = StIdle;
    endcase
  end

  // datapath control
  always_comb begin
    ctrl     = '0;
    left_in  = right_val[0];
    right_in = left_val[0];
    lcnt_d   = lcnt_q;
    rcnt_d   = rcnt_q;
    ov_d     = ov_q;
    valid_d  = 1'b0;
    res_d    = res_q;
    case (state_q)
      StIdle: begin
        if (accept && !key_item_i.command) begin
          if (key_item_i.key == KeyLeft) begin
            if (lcnt_q != '0 && rcnt_q < CntW'(Capacity)) begin
              ctrl.pop_l  = 1'b1;
              ctrl.push_r = 1'b1;
              lcnt_d      = lcnt_q - 1'b1;
              rcnt_d      = rcnt_q + 1'b1;
            end
          end else if (key_item_i.key == KeyRight) begin
            if (rcnt_q != '0 && lcnt_q < CntW'(Capacity)) begin
              ctrl.pop_r  = 1'b1;
              ctrl.push_l = 1'b1;
              lcnt_d      = lcnt_q + 1'b1;
              rcnt_d      = rcnt_q - 1'b1;
            end
          end else if (key_item_i.key == KeyDel) begin
            if (lcnt_q != '0) begin
              ctrl.pop_l = 1'b1;
              lcnt_d     = lcnt_q - 1'b1;
            end
          end else begin
            if (total < (CntW + 1)'(Capacity)) begin
              left_in     = key_item_i.key;
              ctrl.push_l = 1'b1;
              lcnt_d      = lcnt_q + 1'b1;
            end else begin
              ov_d = 1'b1;
            end
          end
        end
      end
      StMove: begin
        // move whole left stack onto the right one so popping gives line order
        if (lcnt_q != '0) begin
          ctrl.pop_l  = 1'b1;
          ctrl.push_r = 1'b1;
          lcnt_d      = lcnt_q - 1'b1;
          rcnt_d      = rcnt_q + 1'b1;
        end
      end
      StEmit: begin
        if (rcnt_q != '0) begin
          ctrl.pop_r = 1'b1;
          rcnt_d     = rcnt_q - 1'b1;
          valid_d    = 1'b1;
          res_d      = '{char_out: right_val[0], is_newline: 1'b0, overflowed: 1'b0};
        end
      end
      StNewline: begin
        valid_d = 1'b1;
        res_d   = '{char_out: 8'h00, is_newline: 1'b1, overflowed: ov_q};
        ov_d    = 1'b0;
        lcnt_d  = '0;
        rcnt_d  = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      lcnt_q  <= '0;
      rcnt_q  <= '0;
      ov_q    <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      lcnt_q  <= lcnt_d;
      rcnt_q  <= rcnt_d;
      ov_q    <= ov_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic [7:0] lp, ln, rp, rn;
    if (i == 0) begin : g_top
      assign lp = left_in;
      assign rp = right_in;
    end else begin : g_mid
      assign lp = left_val[i-1];
      assign rp = right_val[i-1];
    end
    if (i == Capacity - 1) begin : g_bot
      assign ln = left_val[i];
      assign rn = right_val[i];
    end else begin : g_up
      assign ln = left_val[i+1];
      assign rn = right_val[i+1];
    end
    kle_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .left_prev_i (lp),
      .left_next_i (ln),
      .right_prev_i(rp),
      .right_next_i(rn),
      .left_o      (left_val[i]),
      .right_o     (right_val[i])
    );
  end

  assign busy           = (state_q != StIdle);
  assign result_valid_o = valid_q;
  assign result_o       = res_q;

endmodule

`default_nettype wire

[hw/rtl/kle_cell.sv]
// One cell of the two-stack chain: holds one left-stack and one right-stack byte.
// Depends on kle_pkg (cell_ctrl_t).
`default_nettype none

module kle_cell
  import kle_pkg::*;
(
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  logic [7:0] left_prev_i,
  input  logic [7:0] left_next_i,
  input  logic [7:0] right_prev_i,
  input  logic [7:0] right_next_i,
  output logic [7:0] left_o,
  output logic [7:0] right_o
);

  logic [7:0] left_q, left_d;
  logic [7:0] right_q, right_d;

  always_comb begin
    left_d = left_q;
    if (ctrl_i.push_l) begin
      left_d = left_prev_i;
    end else if (ctrl_i.pop_l) begin
      left_d = left_next_i;
    end
  end

  always_comb begin
    right_d = right_q;
    if (ctrl_i.push_r) begin
      right_d = right_prev_i;
    end else if (ctrl_i.pop_r) begin
      right_d = right_next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    left_q  <= left_d;
    right_q <= right_d;
  end

  assign left_o  = left_q;
  assign right_o = right_q;

endmodule

`default_nettype wire

[hw/rtl/kle_checker.sv]
// Port-level checks for the keystroke line editor, bound to the top level.
// Depends on kle_pkg (word types).
`default_nettype none

module kle_checker
  import kle_pkg::*;
(
  input logic         clk_i,
  input logic         rst_ni,
  input logic         start,
  input key_word_t    key_item_i,
  input logic         busy,
  input logic         result_valid_o,
  input result_word_t result_o
);

  a_eol_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && key_item_i.command) |=> busy)
    else $error("end of line did not raise busy");

  a_key_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !key_item_i.command) |=> !busy)
    else $error("keystroke raised busy");

  a_char_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.is_newline) |-> ($past(busy) && !result_o.overflowed))
    else $error("char word outside an emit run or flagged");

  a_newline_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.is_newline) |-> (result_o.char_out == 8'h00 && !busy))
    else $error("bad newline word");

endmodule

bind keystroke_line_editor kle_checker u_kle_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .key_item_i    (key_item_i),
  .busy          (busy),
  .result_valid_o(result_valid_o),
  .result_o      (result_o)
);

`default_nettype wire

[sim/tb_keystroke_line_editor.sv]
// Testbench for keystroke_line_editor: random and directed keystroke words,
// checked against an in-bench gap buffer predictor. Depends on kle_pkg.
`timescale 1ns / 1ps

module tb_keystroke_line_editor;
  import kle_pkg::*;

  localparam int unsigned Cap = CapacityDefault;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RandomWords = 350;

  logic         clk_i;
  logic         rst_ni;
  logic         start = 1'b0;
  key_word_t    key_item_i = '0;
  logic         busy;
  logic         result_valid_o;
  result_word_t result_o;

  keystroke_line_editor u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .key_item_i     (key_item_i),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // predicted line state
  logic [7:0] left_chars [Cap];
  logic [7:0] right_chars [Cap];
  int unsigned n_left;
  int unsigned n_right;
  bit line_ovf;

  key_word_t    pending_keys [$];
  result_word_t emit_expect [$];

  bit        stim_on;
  bit        drv_valid;
  bit        word_taken;
  bit        calm;
  int        gap_left;
  key_word_t drv_word = '0;

  int unsigned cycles;
  int unsigned mismatches;
  int unsigned keys_done;
  int unsigned lines_done;
  int unsigned ovf_lines;
  int unsigned chars_checked;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void queue_key(logic cmd, logic [7:0] k);
    key_word_t w;
    w.command = cmd;
    w.key = k;
    pending_keys.push_back(w);
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] k;
    do k = 8'($urandom_range(0, 255));
    while (k == KeyLeft || k == KeyRight || k == KeyDel);
    return k;
  endfunction

  function automatic void edit_line(key_word_t w);
    result_word_t r;
    int unsigned i;
    if (w.command) begin
      for (i = 0; i < n_left; i++) begin
        r.char_out = left_chars[i];
        r.is_newline = 1'b0;
        r.overflowed = 1'b0;
        emit_expect.push_back(r);
      end
      for (i = n_right; i > 0; i--) begin
        r.char_out = right_chars[i-1];
        r.is_newline = 1'b0;
        r.overflowed = 1'b0;
        emit_expect.push_back(r);
      end
      r.char_out = 8'h00;
      r.is_newline = 1'b1;
      r.overflowed = line_ovf;
      emit_expect.push_back(r);
      lines_done++;
      if (line_ovf) ovf_lines++;
      n_left = 0;
      n_right = 0;
      line_ovf = 1'b0;
    end else begin
      keys_done++;
      case (w.key)
        KeyLeft: begin
          if (n_left > 0 && n_right < Cap) begin
            n_left--;
            right_chars[n_right] = left_chars[n_left];
            n_right++;
          end
        end
        KeyRight: begin
          if (n_right > 0 && n_left < Cap) begin
            n_right--;
            left_chars[n_left] = right_chars[n_right];
            n_left++;
          end
        end
        KeyDel: begin
          if (n_left > 0) n_left--;
        end
        default: begin
          if (n_left + n_right < Cap) begin
            left_chars[n_left] = w.key;
            n_left++;
          end else begin
            line_ovf = 1'b1;
          end
        end
      endcase
    end
  endfunction

  // driver: next word presented at the falling edge
  always @(negedge clk_i) begin : drive
    if (stim_on && (!drv_valid || word_taken)) begin
      drv_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_keys.size() > 0) begin
        if ($urandom_range(0, 39) == 0) calm = !calm;
        if (!calm && pending_keys.size() > 60 && $urandom_range(0, 4) == 0) begin
          gap_left = $urandom_range(1, 13) - 1;
        end else begin
          drv_word = pending_keys.pop_front();
          drv_valid = 1'b1;
        end
      end
    end
    start <= drv_valid;
    key_item_i <= drv_word;
  end

  // monitor: accept words and check emitted words at the rising edge
  always @(posedge clk_i) begin : monitor
    result_word_t exp_w;
    if (rst_ni) begin
      word_taken = start && !busy;
      if (word_taken) edit_line(key_item_i);
      if (result_valid_o) begin
        if (emit_expect.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: char %02h nl %b ov %b",
                     result_o.char_out, result_o.is_newline, result_o.overflowed);
        end else begin
          exp_w = emit_expect.pop_front();
          chars_checked++;
          if (result_o !== exp_w) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp char %02h nl %b ov %b, got char %02h nl %b ov %b",
                       exp_w.char_out, exp_w.is_newline, exp_w.overflowed,
                       result_o.char_out, result_o.is_newline, result_o.overflowed);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d words still expected",
               cycles, emit_expect.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned len;
    int unsigned sel;
    int unsigned j;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: ends of the line, delete at start, extreme bytes, key ignored on EOL
    queue_key(1'b1, 8'h00);
    queue_key(1'b0, KeyLeft);
    queue_key(1'b0, KeyRight);
    queue_key(1'b0, KeyDel);
    queue_key(1'b0, 8'h00);
    queue_key(1'b0, 8'hFF);
    queue_key(1'b0, 8'h41);
    queue_key(1'b0, KeyLeft);
    queue_key(1'b0, KeyLeft);
    queue_key(1'b0, KeyLeft);
    queue_key(1'b0, KeyLeft);
    queue_key(1'b0, KeyDel);
    queue_key(1'b0, KeyRight);
    queue_key(1'b0, 8'h7F);
    queue_key(1'b0, KeyRight);
    queue_key(1'b0, KeyRight);
    queue_key(1'b0, KeyRight);
    queue_key(1'b0, KeyDel);
    queue_key(1'b0, KeyLeft);
    queue_key(1'b1, KeyLeft);
    queue_key(1'b1, 8'hFF);

    j = pending_keys.size();
    while (pending_keys.size() < j + RandomWords) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        // fill to 28..36 bytes, walk the cursor, then inserts that overflow when full
        len = $urandom_range(28, 36);
        repeat (len) queue_key(1'b0, plain_byte());
        len = $urandom_range(0, 34);
        repeat (len) queue_key(1'b0, KeyLeft);
        len = $urandom_range(0, 3);
        repeat (len) queue_key(1'b0, plain_byte());
        len = $urandom_range(0, 6);
        repeat (len) queue_key(1'b0, KeyRight);
        queue_key(1'b1, 8'($urandom_range(0, 255)));
      end else if (sel == 1) begin
        len = $urandom_range(1, 4);
        repeat (len) queue_key(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end else begin
        len = $urandom_range(0, 12);
        repeat (len) begin
          sel = $urandom_range(0, 19);
          if (sel < 10) queue_key(1'b0, 8'($urandom_range(0, 255)));
          else if (sel < 14) queue_key(1'b0, KeyLeft);
          else if (sel < 17) queue_key(1'b0, KeyRight);
          else queue_key(1'b0, KeyDel);
        end
        queue_key(1'b1, 8'($urandom_range(0, 255)));
      end
    end

    stim_on = 1'b1;
    while (pending_keys.size() > 0 || drv_valid) @(posedge clk_i);
    while (emit_expect.size() > 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("run covered %0d keystrokes and %0d lines (%0d overflowed), %0d words checked",
             keys_done, lines_done, ovf_lines, chars_checked);
    if (mismatches == 0 && emit_expect.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d words never seen", mismatches, emit_expect.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
